/* hdl/stdp_synapse_update_core_macros.svh */
// Assertion helpers shared by the core's modules.
// Each macro expects clk and arst_n in the enclosing scope.
`ifndef STDP_SYNAPSE_UPDATE_CORE_MACROS_SVH
`define STDP_SYNAPSE_UPDATE_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define STDPSU_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define STDPSU_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/stdpsu_pkg.sv */
package stdpsu_pkg;

	localparam int WEIGHT_W   = 24;
	localparam int TIME_W     = 32;
	localparam int IDX_W      = 10;
	localparam int FUNC_W     = 2;
	localparam int CFG_INDEX_W = 8;
	localparam int CFG_DATA_W = 23;
	localparam int FACTOR_W   = 17;
	localparam int PROD_W     = 42;

	// event kinds carried in tuser
	localparam logic [FUNC_W-1:0] FUNC_PRE    = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_POST   = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_UPDATE = 2'd2;

	// configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_PLASTIC_ENABLE = 8'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_WEIGHT_MAX     = 8'd1;

	// Q8.16 constants
	localparam logic signed [WEIGHT_W-1:0] Q_PRE_TRACE  = 24'sd6554;
	localparam logic signed [WEIGHT_W-1:0] Q_POST_TRACE = -24'sd7864;
	localparam logic signed [WEIGHT_W+1:0] Q_DRIFT      = 26'sd655;
	localparam logic [FACTOR_W-1:0]        Q_FILTER     = 17'd58982;
	localparam logic signed [PROD_W-1:0]   Q_ROUND      = 42'sd32768;
	localparam logic signed [WEIGHT_W-1:0] Q_MAX24      = 24'sh7FFFFF;
	localparam logic signed [WEIGHT_W-1:0] Q_MIN24      = 24'sh800000;

	typedef struct packed {
		logic signed [WEIGHT_W-1:0] weight;
		logic signed [WEIGHT_W-1:0] change;
		logic signed [WEIGHT_W-1:0] potent;
		logic signed [WEIGHT_W-1:0] depress;
		logic [TIME_W-1:0]          last_pre;
		logic [TIME_W-1:0]          last_post;
	} syn_entry_t;

	typedef struct packed {
		logic clear;
		logic read;
		logic div;
		logic rom;
		logic mul;
		logic write;
	} cmd_t;

	typedef struct packed {
		logic clear_last;
		logic out_free;
	} status_t;

	// exp(-1/tau) in Q2.30 by its Taylor series; x is 1/tau in Q2.30
	function automatic longint unsigned exp_neg(longint unsigned x);
		longint unsigned term;
		longint          e1;
		term = 64'd1 << 30;
		e1   = longint'(64'd1 << 30);
		for (int n = 1; n <= 24; n++) begin
			term = ((term * x) >> 30) / 64'(n);
			if (n % 2 == 1)
				e1 = e1 - longint'(term);
			else
				e1 = e1 + longint'(term);
		end
		if (e1 < 0)
			e1 = 0;
		return longint'(e1);
	endfunction

	// exp(-k/tau) in unsigned Q1.16, built by repeated Q2.30 products
	function automatic logic [FACTOR_W-1:0] decay_entry(longint unsigned e1, int k);
		longint unsigned r;
		r = 64'd1 << 30;
		for (int i = 0; i < k; i++)
			r = (r * e1 + (64'd1 << 29)) >> 30;
		return FACTOR_W'((r + (64'd1 << 13)) >> 14);
	endfunction

endpackage

/* hdl/stdpsu_ctrl.sv */
`include "stdp_synapse_update_core_macros.svh"

module stdpsu_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                load,
	input  stdpsu_pkg::status_t status,
	output stdpsu_pkg::cmd_t    cmd
);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_DIV,
		ST_ROM,
		ST_MUL,
		ST_WRITE
	} state_t;

	state_t           state_q;
	stdpsu_pkg::cmd_t cmd_q;
	logic             ready_q;

	assign load     = in_valid & ready_q;
	assign in_ready = ready_q;
	assign cmd      = cmd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			cmd_q       <= '0;
			cmd_q.clear <= 1'b1;
			ready_q     <= 1'b0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					if (status.clear_last) begin
						state_q     <= ST_IDLE;
						cmd_q.clear <= 1'b0;
						ready_q     <= 1'b1;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						state_q    <= ST_READ;
						ready_q    <= 1'b0;
						cmd_q.read <= 1'b1;
					end
				end
				ST_READ: begin
					state_q    <= ST_DIV;
					cmd_q.read <= 1'b0;
					cmd_q.div  <= 1'b1;
				end
				ST_DIV: begin
					state_q   <= ST_ROM;
					cmd_q.div <= 1'b0;
					cmd_q.rom <= 1'b1;
				end
				ST_ROM: begin
					state_q   <= ST_MUL;
					cmd_q.rom <= 1'b0;
					cmd_q.mul <= 1'b1;
				end
				ST_MUL: begin
					state_q     <= ST_WRITE;
					cmd_q.mul   <= 1'b0;
					cmd_q.write <= 1'b1;
				end
				ST_WRITE: begin
					// hold until the result register can take the new result
					if (status.out_free) begin
						state_q     <= ST_IDLE;
						cmd_q.write <= 1'b0;
						ready_q     <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
					cmd_q   <= '0;
					ready_q <= 1'b1;
				end
			endcase
		end
	end

	`STDPSU_ASSERT_NOW(a_one_step, 1'b1, $onehot0({cmd_q.clear, cmd_q.read, cmd_q.div, cmd_q.rom, cmd_q.mul, cmd_q.write, ready_q}), "more than one step active")
	`STDPSU_ASSERT_NEXT(a_load_reads, load, cmd_q.read && !ready_q, "accepted item did not start a read")
	`STDPSU_ASSERT_NEXT(a_write_done, cmd_q.write && status.out_free, ready_q && !cmd_q.write, "write step did not retire")
	`STDPSU_ASSERT_NEXT(a_clear_done, cmd_q.clear && status.clear_last, ready_q && !cmd_q.clear, "clearing pass did not end")

endmodule

/* hdl/stdpsu_datapath.sv */
module stdpsu_datapath #(
	parameter int NUM_SYNAPSES    = 1024,
	parameter int TICKS_PER_MILLI = 16,
	parameter int TAU_MILLI       = 20,
	parameter int DECAY_ENTRIES   = 256
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  stdpsu_pkg::cmd_t                         cmd,
	input  logic                                     load,
	input  logic [stdpsu_pkg::FUNC_W-1:0]            in_func,
	input  logic [stdpsu_pkg::IDX_W-1:0]             in_idx,
	input  logic [stdpsu_pkg::TIME_W-1:0]            in_time,
	input  logic                                     cfg_we,
	input  logic [stdpsu_pkg::CFG_INDEX_W-1:0]       cfg_index,
	input  logic [stdpsu_pkg::CFG_DATA_W-1:0]        cfg_data,
	input  logic                                     out_ready,
	output logic                                     out_valid,
	output logic signed [stdpsu_pkg::WEIGHT_W-1:0]   out_current,
	output logic signed [stdpsu_pkg::WEIGHT_W-1:0]   out_weight,
	output stdpsu_pkg::status_t                      status
);

	localparam int AW     = (NUM_SYNAPSES > 1) ? $clog2(NUM_SYNAPSES) : 1;
	localparam int IXW    = 17;
	localparam int LIMIT  = DECAY_ENTRIES * TICKS_PER_MILLI;
	localparam int DW     = $clog2(LIMIT);
	localparam int RW     = DW + 1;
	localparam int QW     = 2 * DW + 1;
	localparam int TL     = $clog2(TICKS_PER_MILLI);
	localparam int SH     = DW + TL;
	localparam int IW     = $clog2(DECAY_ENTRIES);
	localparam longint unsigned RECIP =
		((64'd1 << SH) + 64'(TICKS_PER_MILLI) - 64'd1) / 64'(TICKS_PER_MILLI);
	localparam logic [DW:0] RECIP_C = RW'(RECIP);
	localparam longint unsigned DECAY_X  = (64'd1 << 30) / 64'(TAU_MILLI);
	localparam longint unsigned DECAY_E1 = stdpsu_pkg::exp_neg(DECAY_X);

	// decay factors, one per whole millisecond of elapsed time
	logic [stdpsu_pkg::FACTOR_W-1:0] rom_c [DECAY_ENTRIES];

	for (genvar k = 0; k < DECAY_ENTRIES; k++) begin : g_rom
		assign rom_c[k] = stdpsu_pkg::decay_entry(DECAY_E1, k);
	end

	stdpsu_pkg::syn_entry_t mem [NUM_SYNAPSES];

	logic                                    plastic_q;
	logic [stdpsu_pkg::CFG_DATA_W-1:0]       wmax_q;
	logic [AW-1:0]                           clr_cnt_q;
	logic [stdpsu_pkg::FUNC_W-1:0]           func_q;
	logic [stdpsu_pkg::TIME_W-1:0]           now_q;
	logic [AW-1:0]                           addr_q;
	logic                                    idx_ok_q;
	stdpsu_pkg::syn_entry_t                  rd_q;
	logic [IW-1:0]                           ms_q;
	logic                                    win_q;
	logic [stdpsu_pkg::FACTOR_W-1:0]         factor_q;
	logic signed [stdpsu_pkg::PROD_W-1:0]    prod_q;
	logic                                    out_valid_q;
	logic signed [stdpsu_pkg::WEIGHT_W-1:0]  out_cur_q;
	logic signed [stdpsu_pkg::WEIGHT_W-1:0]  out_wgt_q;

	logic [IXW-1:0]                          idx_ext_c;
	logic [stdpsu_pkg::TIME_W-1:0]           then_c;
	logic [stdpsu_pkg::TIME_W-1:0]           elapsed_c;
	logic                                    in_win_c;
	logic [QW-1:0]                           quo_c;
	logic signed [stdpsu_pkg::WEIGHT_W-1:0]  mul_a_c;
	logic [stdpsu_pkg::FACTOR_W-1:0]         mul_b_c;
	logic signed [stdpsu_pkg::PROD_W-1:0]    rnd_c;
	logic signed [stdpsu_pkg::WEIGHT_W-1:0]  scaled_c;
	logic signed [stdpsu_pkg::WEIGHT_W:0]    sum_c;
	logic signed [stdpsu_pkg::WEIGHT_W-1:0]  sat_c;
	logic signed [stdpsu_pkg::WEIGHT_W+1:0]  upd_c;
	logic signed [stdpsu_pkg::WEIGHT_W-1:0]  clamp_c;
	stdpsu_pkg::syn_entry_t                  new_c;
	logic                                    we_item_c;
	logic signed [stdpsu_pkg::WEIGHT_W-1:0]  cur_c;
	logic signed [stdpsu_pkg::WEIGHT_W-1:0]  wgt_c;
	logic                                    out_load_c;
	logic                                    mem_we_c;
	logic [AW-1:0]                           mem_addr_c;
	stdpsu_pkg::syn_entry_t                  mem_data_c;

	assign status.out_free   = !out_valid_q || out_ready;
	assign status.clear_last = (clr_cnt_q == AW'(NUM_SYNAPSES - 1));
	assign out_valid   = out_valid_q;
	assign out_current = out_cur_q;
	assign out_weight  = out_wgt_q;

	assign idx_ext_c = IXW'(in_idx);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plastic_q <= 1'b1;
			wmax_q    <= 23'd65536;
		end else if (cfg_we) begin
			case (cfg_index)
				stdpsu_pkg::REG_PLASTIC_ENABLE: plastic_q <= cfg_data[0];
				stdpsu_pkg::REG_WEIGHT_MAX:     wmax_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// clearing pass address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			clr_cnt_q <= '0;
		else if (cmd.clear)
			clr_cnt_q <= clr_cnt_q + AW'(1);
	end

	// capture the item
	always_ff @(posedge clk) begin
		if (load) begin
			func_q   <= in_func;
			now_q    <= in_time;
			addr_q   <= idx_ext_c[AW-1:0];
			idx_ok_q <= (idx_ext_c < IXW'(NUM_SYNAPSES));
		end
	end

	// elapsed milliseconds by reciprocal multiply, exact below LIMIT ticks
	assign then_c    = (func_q == stdpsu_pkg::FUNC_PRE) ? rd_q.last_post : rd_q.last_pre;
	assign elapsed_c = now_q - then_c;
	assign in_win_c  = (elapsed_c < 32'(LIMIT));
	assign quo_c     = QW'(elapsed_c[DW-1:0]) * QW'(RECIP_C);

	always_ff @(posedge clk) begin
		if (cmd.div) begin
			ms_q  <= quo_c[SH +: IW];
			win_q <= in_win_c;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rom)
			factor_q <= win_q ? rom_c[ms_q] : '0;
	end

	// shared multiplier: trace times decay, or pending change times filter
	always_comb begin
		case (func_q)
			stdpsu_pkg::FUNC_PRE: begin
				mul_a_c = rd_q.depress;
				mul_b_c = factor_q;
			end
			stdpsu_pkg::FUNC_POST: begin
				mul_a_c = rd_q.potent;
				mul_b_c = factor_q;
			end
			default: begin
				mul_a_c = rd_q.change;
				mul_b_c = stdpsu_pkg::Q_FILTER;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.mul)
			prod_q <= mul_a_c * $signed({1'b0, mul_b_c});
	end

	// round to nearest, ties up
	assign rnd_c    = prod_q + stdpsu_pkg::Q_ROUND;
	assign scaled_c = rnd_c[39:16];
	assign sum_c    = {rd_q.change[23], rd_q.change} + {scaled_c[23], scaled_c};
	assign sat_c    = (sum_c[24] != sum_c[23])
		? (sum_c[24] ? stdpsu_pkg::Q_MIN24 : stdpsu_pkg::Q_MAX24) : sum_c[23:0];
	assign upd_c    = {{2{rd_q.weight[23]}}, rd_q.weight} + stdpsu_pkg::Q_DRIFT
		+ {{2{rd_q.change[23]}}, rd_q.change};

	always_comb begin
		if (upd_c < 0)
			clamp_c = '0;
		else if (upd_c > $signed({3'b000, wmax_q}))
			clamp_c = $signed({1'b0, wmax_q});
		else
			clamp_c = upd_c[23:0];
	end

	always_comb begin
		new_c     = rd_q;
		we_item_c = 1'b0;
		cur_c     = '0;
		case (func_q)
			stdpsu_pkg::FUNC_PRE: begin
				cur_c          = rd_q.weight;
				we_item_c      = plastic_q;
				new_c.depress  = scaled_c;
				new_c.change   = sat_c;
				new_c.potent   = stdpsu_pkg::Q_PRE_TRACE;
				new_c.last_pre = now_q;
			end
			stdpsu_pkg::FUNC_POST: begin
				we_item_c       = plastic_q;
				new_c.potent    = scaled_c;
				new_c.change    = sat_c;
				new_c.depress   = stdpsu_pkg::Q_POST_TRACE;
				new_c.last_post = now_q;
			end
			stdpsu_pkg::FUNC_UPDATE: begin
				we_item_c    = plastic_q;
				new_c.weight = clamp_c;
				new_c.change = scaled_c;
			end
			default: ;
		endcase
		if (!idx_ok_q) begin
			we_item_c = 1'b0;
			cur_c     = '0;
		end
	end

	assign wgt_c      = !idx_ok_q ? '0 : (we_item_c ? new_c.weight : rd_q.weight);
	assign out_load_c = cmd.write && status.out_free;

	assign mem_we_c   = cmd.clear || (out_load_c && we_item_c);
	assign mem_addr_c = cmd.clear ? clr_cnt_q : addr_q;
	assign mem_data_c = cmd.clear ? '0 : new_c;

	always_ff @(posedge clk) begin
		if (mem_we_c)
			mem[mem_addr_c] <= mem_data_c;
		if (cmd.read)
			rd_q <= mem[addr_q];
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load_c)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load_c) begin
			out_cur_q <= cur_c;
			out_wgt_q <= wgt_c;
		end
	end

endmodule

/* hdl/stdp_synapse_update_core.sv */
// Pair-based STDP synapse table. Each synapse keeps a Q8.16 weight, a pending
// weight change, a potentiation and a depression trace, and its last pre and
// post spike times. An input transfer carries one event (tuser: 0 pre spike,
// 1 post spike, 2 periodic weight update) and yields exactly one output
// transfer: the weight as current on a pre spike (else 0) and the weight after
// the event. Traces decay by exp(-ms/TAU_MILLI) from a ROM built at
// elaboration; an elapsed time of DECAY_ENTRIES ms or more zeroes the trace.
// Timing: after reset the block runs a clearing pass over the synapse memory,
// every entry in turn, during which s_axis_tready stays low (configuration
// writes are taken throughout). After that an event walks six steps in order:
// accept, memory read, elapsed-time reciprocal multiply, ROM read,
// trace multiply, then write-back with result load. A new event is taken only
// after the previous one has written back, a consequence of the single-port
// synapse memory and its read-modify-write sequence. The next event is accepted
// while a result still waits in the output register; the write-back step holds
// only if that register is still full.
module stdp_synapse_update_core #(
	parameter int NUM_SYNAPSES    = 1024,
	parameter int TICKS_PER_MILLI = 16,
	parameter int TAU_MILLI       = 20,
	parameter int DECAY_ENTRIES   = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	// event stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,   // [9:0] syn_index, [41:10] event_time, rest zero
	input  logic [1:0]  s_axis_tuser,   // [1:0] func
	// result stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,   // [23:0] current_add, [47:24] weight_out
	// configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [22:0] cfg_data
);

	stdpsu_pkg::cmd_t    cmd;
	stdpsu_pkg::status_t status;
	logic                load;
	logic signed [stdpsu_pkg::WEIGHT_W-1:0] out_current;
	logic signed [stdpsu_pkg::WEIGHT_W-1:0] out_weight;

	// the user must write registers only while idle; the block does not enforce it and takes every transfer at once
	assign cfg_ready = 1'b1;

	stdpsu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.load     (load),
		.status   (status),
		.cmd      (cmd)
	);

	stdpsu_datapath #(
		.NUM_SYNAPSES    (NUM_SYNAPSES),
		.TICKS_PER_MILLI (TICKS_PER_MILLI),
		.TAU_MILLI       (TAU_MILLI),
		.DECAY_ENTRIES   (DECAY_ENTRIES)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.load        (load),
		.in_func     (s_axis_tuser),
		.in_idx      (s_axis_tdata[9:0]),
		.in_time     (s_axis_tdata[41:10]),
		.cfg_we      (cfg_valid),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.out_ready   (m_axis_tready),
		.out_valid   (m_axis_tvalid),
		.out_current (out_current),
		.out_weight  (out_weight),
		.status      (status)
	);

	// pack results, current_add in the low half
	assign m_axis_tdata = {out_weight, out_current};

endmodule

/* tb/sv/testbench.sv */
module testbench;

	import stdpsu_pkg::*;

	localparam int NUM_SYNAPSES    = 1024;
	localparam int TICKS_PER_MILLI = 16;
	localparam int TAU_MILLI       = 20;
	localparam int DECAY_ENTRIES   = 256;

	// Spare event code: the block must leave the synapse alone.
	localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;

	// Learning constants in Q8.16, decay products use Q1.16 factors.
	localparam int          PRE_TRACE_Q  = 6554;
	localparam int          POST_TRACE_Q = -7864;
	localparam int          DRIFT_Q      = 655;
	localparam logic [16:0] FILTER_Q     = 17'd58982;
	localparam longint      SAT_HI       = 8388607;
	localparam longint      SAT_LO       = -8388608;

	// Clearing pass plus ~900 events at worst-case gaps and stalls, several times over.
	localparam int unsigned CYCLE_LIMIT = 200000;

	typedef struct {
		logic signed [23:0] current_add;
		logic signed [23:0] weight_out;
	} synapse_result_t;

	// Shadow of the synapse table: predicts each result as its event is accepted
	// and compares the returned transfers against those predictions in order.
	class synapse_table;
		logic [16:0]        decay_factor[DECAY_ENTRIES];
		bit                 plastic;
		logic [22:0]        w_limit;
		logic signed [23:0] weight[NUM_SYNAPSES];
		logic signed [23:0] change[NUM_SYNAPSES];
		logic signed [23:0] potent[NUM_SYNAPSES];
		logic signed [23:0] depress[NUM_SYNAPSES];
		logic [31:0]        pre_time[NUM_SYNAPSES];
		logic [31:0]        post_time[NUM_SYNAPSES];
		synapse_result_t    due[$];
		int                 mismatches;
		int                 results_seen;
		int                 func_seen[4];
		int                 saturations;
		int                 clamps;

		function new();
			longint unsigned one_q30, ratio, term, r;
			longint          e1;
			one_q30 = 64'd1 << 30;
			ratio   = one_q30 / 64'(TAU_MILLI);
			term    = one_q30;
			e1      = longint'(one_q30);
			// exp(-1/tau) by Taylor series in Q2.30
			for (int n = 1; n <= 24; n++) begin
				term = ((term * ratio) >> 30) / 64'(n);
				if (n % 2 == 1)
					e1 = e1 - longint'(term);
				else
					e1 = e1 + longint'(term);
			end
			if (e1 < 0)
				e1 = 0;
			r = one_q30;
			for (int k = 0; k < DECAY_ENTRIES; k++) begin
				decay_factor[k] = 17'((r + 64'd8192) >> 14);
				r = (r * 64'(e1) + 64'd536870912) >> 30;
			end
			plastic = 1'b1;
			w_limit = 23'd65536;
			for (int i = 0; i < NUM_SYNAPSES; i++) begin
				weight[i]    = '0;
				change[i]    = '0;
				potent[i]    = '0;
				depress[i]   = '0;
				pre_time[i]  = '0;
				post_time[i] = '0;
			end
		endfunction

		// Q8.16 times Q1.16, rounded to nearest with ties upward.
		function logic signed [23:0] scale(logic signed [23:0] a, logic [16:0] f);
			longint p;
			p = longint'(a) * longint'(f) + 64'sd32768;
			return 24'(p >>> 16);
		endfunction

		function logic signed [23:0] saturate(longint v);
			if (v > SAT_HI) begin
				saturations++;
				return 24'(SAT_HI);
			end
			if (v < SAT_LO) begin
				saturations++;
				return 24'(SAT_LO);
			end
			return 24'(v);
		endfunction

		function logic signed [23:0] decayed(logic signed [23:0] trace, logic [31:0] now,
				logic [31:0] since);
			logic [31:0] elapsed;
			logic [31:0] ms;
			elapsed = now - since;
			ms = elapsed / TICKS_PER_MILLI;
			if (ms >= DECAY_ENTRIES)
				return '0;
			return scale(trace, decay_factor[ms]);
		endfunction

		function void take_register(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
			if (index == REG_PLASTIC_ENABLE)
				plastic = data[0];
			else if (index == REG_WEIGHT_MAX)
				w_limit = data;
		endfunction

		function void note_event(logic [FUNC_W-1:0] func, logic [IDX_W-1:0] i, logic [31:0] now);
			synapse_result_t res;
			longint          w;
			res.current_add = '0;
			func_seen[func]++;
			case (func)
				FUNC_PRE: begin
					res.current_add = weight[i];
					if (plastic) begin
						depress[i]  = decayed(depress[i], now, post_time[i]);
						change[i]   = saturate(longint'(change[i]) + longint'(depress[i]));
						potent[i]   = 24'(PRE_TRACE_Q);
						pre_time[i] = now;
					end
				end
				FUNC_POST: begin
					if (plastic) begin
						potent[i]    = decayed(potent[i], now, pre_time[i]);
						change[i]    = saturate(longint'(change[i]) + longint'(potent[i]));
						depress[i]   = 24'(POST_TRACE_Q);
						post_time[i] = now;
					end
				end
				FUNC_UPDATE: begin
					if (plastic) begin
						w = longint'(weight[i]) + DRIFT_Q + longint'(change[i]);
						if (w < 0) begin
							w = 0;
							clamps++;
						end else if (w > longint'(w_limit)) begin
							w = longint'(w_limit);
							clamps++;
						end
						weight[i] = 24'(w);
						change[i] = scale(change[i], FILTER_Q);
					end
				end
				default: ;
			endcase
			res.weight_out = weight[i];
			due = {due, res};
		endfunction

		function void check_result(logic [47:0] word);
			synapse_result_t    want;
			logic signed [23:0] got_current, got_weight;
			got_current = word[23:0];
			got_weight  = word[47:24];
			results_seen++;
			if (due.size() == 0) begin
				$error("result transfer with no event outstanding: current_add %0d, weight_out %0d",
					got_current, got_weight);
				mismatches++;
				return;
			end
			want = due.pop_front();
			if (got_current !== want.current_add) begin
				$error("current_add: expected %0d, got %0d", want.current_add, got_current);
				mismatches++;
			end
			if (got_weight !== want.weight_out) begin
				$error("weight_out: expected %0d, got %0d", want.weight_out, got_weight);
				mismatches++;
			end
		endfunction
	endclass

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata  = '0;
	logic [1:0]  s_axis_tuser  = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [47:0] m_axis_tdata;
	logic        cfg_valid     = 1'b0;
	logic        cfg_ready;
	logic [7:0]  cfg_index     = '0;
	logic [22:0] cfg_data      = '0;

	// Set to suppress idling on both sides for a stretch.
	bit          calm = 1'b0;
	int unsigned cycle_count = 0;

	synapse_table synapses = new();

	stdp_synapse_update_core #(
		.NUM_SYNAPSES   (NUM_SYNAPSES),
		.TICKS_PER_MILLI(TICKS_PER_MILLI),
		.TAU_MILLI      (TAU_MILLI),
		.DECAY_ENTRIES  (DECAY_ENTRIES)
	) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #1 clk = ~clk;

	// Abort a hung run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				synapses.due.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Observe every transfer at the rising edge; inputs were settled at the falling edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready === 1'b1)
				synapses.note_event(s_axis_tuser, s_axis_tdata[9:0], s_axis_tdata[41:10]);
			if (m_axis_tvalid === 1'b1 && m_axis_tready)
				synapses.check_result(m_axis_tdata);
			if (cfg_valid && cfg_ready === 1'b1)
				synapses.take_register(cfg_index, cfg_data);
		end
	end

	// Result side: stall a random number of cycles before taking each result.
	initial begin : result_sink
		int stall;
		forever begin
			stall = calm ? 0 : $urandom_range(10);
			repeat (stall) begin
				@(negedge clk);
				m_axis_tready <= 1'b0;
			end
			@(negedge clk);
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!(m_axis_tvalid === 1'b1 && m_axis_tready));
		end
	end

	// Offer one event after a random gap and hold it until the transfer.
	task automatic push_event(input logic [FUNC_W-1:0] func, input logic [IDX_W-1:0] syn,
			input logic [31:0] stamp);
		int gap;
		gap = calm ? 0 : $urandom_range(10);
		repeat (gap) begin
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {6'd0, stamp, syn};
		s_axis_tuser  <= func;
		do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready === 1'b1));
	endtask

	// Drop valid and wait until every predicted result has been returned.
	task automatic wait_results();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (synapses.due.size() != 0)
			@(posedge clk);
	endtask

	task automatic program_register(input logic [CFG_INDEX_W-1:0] index,
			input logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data  <= value;
		do @(posedge clk); while (!(cfg_valid && cfg_ready === 1'b1));
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Reprogram only with the block drained.
	task automatic set_learning(input bit plastic, input logic [CFG_DATA_W-1:0] limit);
		wait_results();
		program_register(REG_PLASTIC_ENABLE, {22'd0, plastic});
		program_register(REG_WEIGHT_MAX, limit);
	endtask

	initial begin : stimulus
		logic [31:0]       stamp;
		logic [IDX_W-1:0]  syn;
		logic [FUNC_W-1:0] func;
		int                pick;
		int                kind;

		// Hold reset, then release it on a falling edge.
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;

		// Configuration is taken during the clearing pass.
		program_register(REG_PLASTIC_ENABLE, 23'd1);
		program_register(REG_WEIGHT_MAX, 23'd65536);

		// Directed: drift from zero, pre/post pairs, time wrap, table edge, spare code.
		push_event(FUNC_UPDATE, 10'd0, 32'd0);
		push_event(FUNC_PRE, 10'd0, 32'd16);
		push_event(FUNC_POST, 10'd0, 32'd32);
		push_event(FUNC_PRE, 10'd0, 32'd48);
		push_event(FUNC_UPDATE, 10'd0, 32'd48);
		push_event(FUNC_PRE, 10'd1023, 32'hFFFF_FFFF);
		push_event(FUNC_POST, 10'd1023, 32'd5);
		// last ROM entry, then one millisecond past the table
		push_event(FUNC_PRE, 10'd1, 32'd1000);
		push_event(FUNC_POST, 10'd1, 32'd1000 + 32'd4095);
		push_event(FUNC_PRE, 10'd2, 32'd2000);
		push_event(FUNC_POST, 10'd2, 32'd2000 + 32'd4096);
		// depression pulls the weight below zero; update clamps at 0
		push_event(FUNC_POST, 10'd3, 32'd3000);
		push_event(FUNC_PRE, 10'd3, 32'd3000);
		push_event(FUNC_UPDATE, 10'd3, 32'd3000);
		push_event(FUNC_SPARE, 10'd0, 32'd50);
		push_event(FUNC_UPDATE, 10'd1023, 32'hAAAA_5555);

		// Learning off: deliver only.
		set_learning(1'b0, 23'd65536);
		push_event(FUNC_PRE, 10'd0, 32'd100);
		push_event(FUNC_POST, 10'd0, 32'd110);
		push_event(FUNC_UPDATE, 10'd0, 32'd120);

		// Zero ceiling, then full-scale ceiling.
		set_learning(1'b1, 23'd0);
		push_event(FUNC_UPDATE, 10'd0, 32'd130);
		push_event(FUNC_PRE, 10'd512, 32'h5555_AAAA);
		set_learning(1'b1, 23'h7F_FFFF);
		push_event(FUNC_UPDATE, 10'd1, 32'd140);

		// Random: mostly a handful of busy synapses with short, advancing times so
		// traces survive between spikes; the rest scatters indexes and times.
		set_learning(1'b1, 23'd65536);
		stamp = 32'd5000;
		for (int n = 0; n < 850; n++) begin
			if (n > 0 && n % 140 == 0) begin
				calm = 1'b0;
				case (n / 140)
					1: begin
						calm = 1'b1;
						set_learning(1'b1, 23'h7F_FFFF);
					end
					2: set_learning(1'b1, 23'd0);
					3: set_learning(1'b0, 23'($urandom));
					4: set_learning(1'b1, 23'($urandom_range(200000)));
					5: set_learning(1'b1, 23'd65536);
					default: set_learning(1'b1, 23'($urandom_range(1 << 20)));
				endcase
			end
			// Hold the sender until the block is empty, mid-phase.
			if (n == 425)
				wait_results();
			pick = $urandom_range(99);
			kind = $urandom_range(9);
			func = (kind < 4) ? FUNC_PRE : (kind < 8) ? FUNC_POST : FUNC_UPDATE;
			if (pick < 70) begin
				syn = $urandom_range(1) ? 10'(1018 + $urandom_range(5)) : 10'($urandom_range(5));
				stamp += 32'($urandom_range(400));
			end else if (pick < 85) begin
				syn = 10'($urandom);
				stamp += 32'($urandom_range(6000));
			end else if (pick < 93) begin
				syn = 10'($urandom);
				stamp = $urandom;
			end else begin
				syn = 10'($urandom);
				func = FUNC_SPARE;
			end
			push_event(func, syn, stamp);
		end
		calm = 1'b0;

		// Drain, then allow the pipeline depth for any stray result.
		wait_results();
		repeat (12) @(posedge clk);

		$display("Compared %0d results: %0d pre, %0d post, %0d update, %0d spare-code events.",
			synapses.results_seen, synapses.func_seen[FUNC_PRE], synapses.func_seen[FUNC_POST],
			synapses.func_seen[FUNC_UPDATE], synapses.func_seen[FUNC_SPARE]);
		$display("Learning on and off, ceilings 0 to full scale; %0d saturated sums, %0d clamps.",
			synapses.saturations, synapses.clamps);
		if (synapses.mismatches == 0 && synapses.due.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d mismatches, %0d results missing", synapses.mismatches,
				synapses.due.size());
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
